>>> rtl/assert_macros.svh
// assertion macros shared by the checker files
// each macro expects clk and arst_n in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication whose consequent must hold in the cycle after the antecedent
`define BRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/brp_pkg.sv
// shared types, constants and arithmetic helpers of the bump pair force block
// used by every module of the block but the checker; depends on nothing
package brp_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_TOLERANCE    = 2'd0;
	localparam logic [1:0] CFG_FORCE_WEIGHT = 2'd1;

	localparam logic [19:0] TOLERANCE_RESET    = 20'd0;
	localparam logic [23:0] FORCE_WEIGHT_RESET = 24'd65536;

	localparam int ATOM_INDEX_BITS_DEF = 16;
	localparam int SQRT_STEPS  = 32;
	localparam int DIV_STEPS   = 32;
	localparam int FRONT_DEPTH = SQRT_STEPS + 4;
	localparam int BACK_DEPTH  = DIV_STEPS + 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	// pair data carried along the front pipeline
	typedef struct packed {
		logic [15:0]      out_first;
		logic [15:0]      out_second;
		logic [2:0][31:0] mag;
		logic [2:0]       neg;
		logic             gt;
		logic             bonded;
		logic             r1;
		logic             r2;
		logic             last;
		logic [19:0]      contact;
	} fmeta_t;

	// one restoring square root step
	typedef struct packed {
		logic [63:0] rad;
		logic [32:0] rem;
		logic [31:0] root;
	} sqrt_t;

	// classified pair handed from front to back
	typedef struct packed {
		logic [15:0]      out_first;
		logic [15:0]      out_second;
		logic [2:0][31:0] mag;
		logic [2:0]       neg;
		logic             r1;
		logic             r2;
		logic             last;
		logic             bump;
		logic             dz;
		logic [19:0]      d;
		logic [28:0]      w;
	} item_t;

	// queue status seen by both sides
	typedef struct packed {
		logic not_empty;
		logic full;
	} qstat_t;

	// pair data carried along the back pipeline
	typedef struct packed {
		logic [15:0] out_first;
		logic [15:0] out_second;
		logic [2:0]  neg;
		logic        r1;
		logic        r2;
		logic        last;
		logic        bump;
		logic        dz;
		logic [19:0] d;
		logic [31:0] viol;
	} bmeta_t;

	// one long division lane
	typedef struct packed {
		logic [19:0] rem;
		logic [31:0] low;
		logic [31:0] q;
		logic        ovf;
	} div_t;

	function automatic sqrt_t sqrt_step(input sqrt_t s);
		logic [34:0] t;
		logic [34:0] c;
		sqrt_t r;
		t = {s.rem, s.rad[63:62]};
		c = {1'b0, s.root, 2'b01};
		r.rad = {s.rad[61:0], 2'b00};
		if (t >= c) begin
			r.rem  = 33'(t - c);
			r.root = {s.root[30:0], 1'b1};
		end else begin
			r.rem  = t[32:0];
			r.root = {s.root[30:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div_t div_step(input div_t s, input logic [19:0] d);
		logic [20:0] t;
		div_t r;
		t = {s.rem, s.low[31]};
		r.low = {s.low[30:0], 1'b0};
		r.ovf = s.ovf;
		if (t >= {1'b0, d}) begin
			r.rem = 20'(t - {1'b0, d});
			r.q   = {s.q[30:0], 1'b1};
		end else begin
			r.rem = t[19:0];
			r.q   = {s.q[30:0], 1'b0};
		end
		return r;
	endfunction

	// saturate +q or -q to the signed 32 bit range, q up to 2^32
	function automatic logic [31:0] sat_s32(input logic [32:0] q, input logic negate);
		logic [31:0] r;
		if (negate) begin
			if (q > 33'h0_8000_0000) r = 32'h8000_0000;
			else r = 32'(-q[31:0]);
		end else begin
			if (q >= 33'h0_8000_0000) r = 32'h7FFF_FFFF;
			else r = q[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/brp_front.sv
// front pipeline: squares, distance square root, bump test and weighted overlap
// depends on brp_pkg
module brp_front #(
	parameter int ATOM_INDEX_BITS = brp_pkg::ATOM_INDEX_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [15:0]     atom_first,
	input  logic [15:0]     atom_second,
	input  logic [31:0]     delta_x,
	input  logic [31:0]     delta_y,
	input  logic [31:0]     delta_z,
	input  logic [19:0]     contact_distance,
	input  logic            pair_bonded,
	input  logic            first_restrained,
	input  logic            second_restrained,
	input  logic            end_of_list,
	input  logic [19:0]     tolerance,
	input  logic [23:0]     force_weight,
	input  brp_pkg::qstat_t qstat,
	output logic            push,
	output brp_pkg::item_t  item
);

	localparam int D = brp_pkg::FRONT_DEPTH;
	localparam int S = brp_pkg::SQRT_STEPS;

	logic [D-1:0] vld_q;
	logic         adv;

	logic [ATOM_INDEX_BITS-1:0] idx1, idx2;
	logic [2:0][31:0] dc;
	brp_pkg::fmeta_t  meta_in;
	logic [2:0][63:0] sq_in;

	brp_pkg::fmeta_t  meta_s1, meta_s2;
	logic [2:0][63:0] sq_s1;
	logic [63:0]      sum_s2;
	brp_pkg::sqrt_t   root_s3 [S];
	brp_pkg::fmeta_t  meta_s3 [S];
	brp_pkg::sqrt_t   root_init;

	logic signed [20:0] lb;
	logic [31:0]        d_root;
	logic               bump_c;
	logic [20:0]        f_c;
	brp_pkg::fmeta_t    meta_s35;
	logic               bump_s35;
	logic [20:0]        f_s35;
	logic [19:0]        d_s35;
	logic               dz_s35;
	logic [44:0]        prod;
	brp_pkg::item_t     item_s36;

	// whole pipeline moves together, held when the last stage is valid and the queue is full
	assign adv      = !vld_q[D-1] || !qstat.full;
	assign in_stall = !adv;
	assign push     = vld_q[D-1] && !qstat.full;
	assign item     = item_s36;

	// input classification and magnitudes
	always_comb begin
		idx1 = ATOM_INDEX_BITS'(atom_first);
		idx2 = ATOM_INDEX_BITS'(atom_second);
		dc   = {delta_z, delta_y, delta_x};
		meta_in.out_first  = 16'(idx1);
		meta_in.out_second = 16'(idx2);
		meta_in.gt         = idx1 > idx2;
		meta_in.bonded     = pair_bonded;
		meta_in.r1         = first_restrained;
		meta_in.r2         = second_restrained;
		meta_in.last       = end_of_list;
		meta_in.contact    = contact_distance;
		for (int i = 0; i < 3; i++) begin
			meta_in.neg[i] = dc[i][31];
			meta_in.mag[i] = dc[i][31] ? 32'(-dc[i]) : dc[i];
			sq_in[i]       = 64'(meta_in.mag[i]) * 64'(meta_in.mag[i]);
		end
	end

	assign root_init = '{rad: sum_s2, rem: '0, root: '0};

	// bump test against the lower bound
	always_comb begin
		d_root = root_s3[S-1].root;
		lb     = $signed({1'b0, meta_s3[S-1].contact}) - $signed({1'b0, tolerance});
		bump_c = meta_s3[S-1].gt && !meta_s3[S-1].bonded
			&& !(meta_s3[S-1].r1 && meta_s3[S-1].r2)
			&& (lb > 21'sd0) && (d_root < {11'b0, lb});
		f_c    = 21'(lb) - d_root[20:0];
		prod   = 45'(force_weight) * 45'(f_s35);
	end

	// stage valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[D-2:0], in_valid};
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1    <= meta_in;
			sq_s1      <= sq_in;
			meta_s2    <= meta_s1;
			sum_s2     <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			root_s3[0] <= brp_pkg::sqrt_step(root_init);
			meta_s3[0] <= meta_s2;
			for (int j = 1; j < S; j++) begin
				root_s3[j] <= brp_pkg::sqrt_step(root_s3[j-1]);
				meta_s3[j] <= meta_s3[j-1];
			end
			meta_s35 <= meta_s3[S-1];
			bump_s35 <= bump_c;
			f_s35    <= f_c;
			d_s35    <= d_root[19:0];
			dz_s35   <= d_root == 32'd0;
			item_s36.out_first  <= meta_s35.out_first;
			item_s36.out_second <= meta_s35.out_second;
			item_s36.mag        <= meta_s35.mag;
			item_s36.neg        <= meta_s35.neg;
			item_s36.r1         <= meta_s35.r1;
			item_s36.r2         <= meta_s35.r2;
			item_s36.last       <= meta_s35.last;
			item_s36.bump       <= bump_s35;
			item_s36.dz         <= dz_s35;
			item_s36.d          <= d_s35;
			item_s36.w          <= prod[44:16];
		end
	end

endmodule

>>> rtl/brp_queue.sv
// short queue between the front and back pipelines
// depends on brp_pkg
module brp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  brp_pkg::item_t  wr_item,
	input  logic            pop,
	output brp_pkg::item_t  rd_item,
	output brp_pkg::qstat_t qstat
);

	localparam int N = brp_pkg::QUEUE_DEPTH;
	localparam int P = brp_pkg::QUEUE_PTR_BITS;

	brp_pkg::item_t mem_q [N];
	logic [P-1:0]   wr_ptr_q, rd_ptr_q;
	logic [P:0]     count_q;

	assign qstat.not_empty = count_q != '0;
	assign qstat.full      = count_q == (P+1)'(N);
	assign rd_item         = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == P'(N-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == P'(N-1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (P+1)'(push) - (P+1)'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

>>> rtl/brp_back.sv
// back pipeline: force numerators, three pipelined dividers, saturation
// depends on brp_pkg
module brp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  brp_pkg::item_t  item,
	input  brp_pkg::qstat_t qstat,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [15:0]     out_first,
	output logic [15:0]     out_second,
	output logic [31:0]     force_first_x,
	output logic [31:0]     force_first_y,
	output logic [31:0]     force_first_z,
	output logic [31:0]     force_second_x,
	output logic [31:0]     force_second_y,
	output logic [31:0]     force_second_z,
	output logic            apply_first,
	output logic            apply_second,
	output logic [31:0]     violation_term,
	output logic            last_result
);

	localparam int D = brp_pkg::BACK_DEPTH;
	localparam int S = brp_pkg::DIV_STEPS;

	logic [D-1:0] vld_q;
	logic         adv;

	brp_pkg::bmeta_t  meta_in;
	logic [2:0][61:0] num_in;
	brp_pkg::bmeta_t  meta_s1, meta_s2;
	logic [2:0][61:0] num_s1;
	brp_pkg::div_t    div_init [3];
	brp_pkg::div_t    div_s2 [3];
	brp_pkg::div_t    div_s3 [S][3];
	brp_pkg::bmeta_t  meta_s3 [S];

	brp_pkg::bmeta_t  mf;
	logic [2:0][32:0] qmag;
	logic [2:0][31:0] ff, fs;
	logic [60:0]      p;

	// output register is the last stage
	assign adv       = !vld_q[D-1] || !out_stall;
	assign pop       = adv && qstat.not_empty;
	assign out_valid = vld_q[D-1];

	// numerators mag * w * k and violation term
	always_comb begin
		meta_in.out_first  = item.out_first;
		meta_in.out_second = item.out_second;
		meta_in.neg        = item.neg;
		meta_in.r1         = item.r1;
		meta_in.r2         = item.r2;
		meta_in.last       = item.last;
		meta_in.bump       = item.bump;
		meta_in.dz         = item.dz;
		meta_in.d          = item.d;
		meta_in.viol       = (32'(item.w) << 2) + (32'(item.w) << 1);
		p = '0;
		for (int i = 0; i < 3; i++) begin
			p         = 61'(item.mag[i]) * 61'(item.w);
			num_in[i] = (item.r1 || item.r2) ? {p, 1'b0} : {1'b0, p};
		end
	end

	// overflow check and divider start
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			div_init[i].ovf = num_s1[i] >= {10'b0, meta_s1.d, 32'b0};
			div_init[i].rem = num_s1[i][51:32];
			div_init[i].low = num_s1[i][31:0];
			div_init[i].q   = '0;
		end
	end

	// final quotient, sign and saturation
	always_comb begin
		mf = meta_s3[S-1];
		for (int i = 0; i < 3; i++) begin
			if (mf.dz) qmag[i] = '0;
			else if (div_s3[S-1][i].ovf) qmag[i] = 33'h1_0000_0000;
			else qmag[i] = {1'b0, div_s3[S-1][i].q};
			ff[i] = (mf.bump && !mf.r1) ? brp_pkg::sat_s32(qmag[i], !mf.neg[i]) : '0;
			fs[i] = (mf.bump && !mf.r2) ? brp_pkg::sat_s32(qmag[i], mf.neg[i]) : '0;
		end
	end

	// stage valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[D-2:0], qstat.not_empty};
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_in;
			num_s1  <= num_in;
			meta_s2 <= meta_s1;
			for (int i = 0; i < 3; i++) begin
				div_s2[i]    <= div_init[i];
				div_s3[0][i] <= brp_pkg::div_step(div_s2[i], meta_s2.d);
			end
			meta_s3[0] <= meta_s2;
			for (int j = 1; j < S; j++) begin
				for (int i = 0; i < 3; i++) begin
					div_s3[j][i] <= brp_pkg::div_step(div_s3[j-1][i], meta_s3[j-1].d);
				end
				meta_s3[j] <= meta_s3[j-1];
			end
			out_first      <= mf.out_first;
			out_second     <= mf.out_second;
			force_first_x  <= ff[0];
			force_first_y  <= ff[1];
			force_first_z  <= ff[2];
			force_second_x <= fs[0];
			force_second_y <= fs[1];
			force_second_z <= fs[2];
			apply_first    <= mf.bump && !mf.r1;
			apply_second   <= mf.bump && !mf.r2;
			violation_term <= mf.bump ? mf.viol : '0;
			last_result    <= mf.last;
		end
	end

endmodule

>>> rtl/bump_repulsion_pair_force_top.sv
// top level of the bump pair force block: config registers, front, queue, back
// depends on brp_pkg, brp_front, brp_queue, brp_back
//
//  channel   handshake               payload
//  input     in_valid / in_stall     pair indices, deltas, contact, flags
//  output    out_valid / out_stall   forces, apply flags, violation term
//  config    cfg_we                  cfg_index, cfg_data
//
// one pair per cycle sustained unless stalled; a pair passes through 36 front
// stages, set by the 32 step square root, one queue entry and 35 back stages,
// set by the 32 step dividers; the first stage loads at the accepting edge
// arst_n clears all stage valids and the queue; config resets to defaults
// an output stall freezes the back; the 4 entry queue fills, then the front freezes
module bump_repulsion_pair_force_top #(
	parameter int ATOM_INDEX_BITS = brp_pkg::ATOM_INDEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] atom_first,
	input  logic [15:0] atom_second,
	input  logic [31:0] delta_x,
	input  logic [31:0] delta_y,
	input  logic [31:0] delta_z,
	input  logic [19:0] contact_distance,
	input  logic        pair_bonded,
	input  logic        first_restrained,
	input  logic        second_restrained,
	input  logic        end_of_list,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_first,
	output logic [15:0] out_second,
	output logic [31:0] force_first_x,
	output logic [31:0] force_first_y,
	output logic [31:0] force_first_z,
	output logic [31:0] force_second_x,
	output logic [31:0] force_second_y,
	output logic [31:0] force_second_z,
	output logic        apply_first,
	output logic        apply_second,
	output logic [31:0] violation_term,
	output logic        last_result
);

	logic [19:0]     tolerance_q;
	logic [23:0]     force_weight_q;
	logic            push, pop;
	brp_pkg::item_t  wr_item, rd_item;
	brp_pkg::qstat_t qstat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q    <= brp_pkg::TOLERANCE_RESET;
			force_weight_q <= brp_pkg::FORCE_WEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == brp_pkg::CFG_TOLERANCE) tolerance_q <= cfg_data[19:0];
			if (cfg_index == brp_pkg::CFG_FORCE_WEIGHT) force_weight_q <= cfg_data;
		end
	end

	brp_front #(.ATOM_INDEX_BITS(ATOM_INDEX_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.atom_first, .atom_second, .delta_x, .delta_y, .delta_z,
		.contact_distance, .pair_bonded, .first_restrained, .second_restrained,
		.end_of_list,
		.tolerance(tolerance_q), .force_weight(force_weight_q),
		.qstat, .push, .item(wr_item)
	);

	brp_queue u_queue (
		.clk, .arst_n, .push, .wr_item, .pop, .rd_item, .qstat
	);

	brp_back u_back (
		.clk, .arst_n, .item(rd_item), .qstat, .pop,
		.out_valid, .out_stall, .out_first, .out_second,
		.force_first_x, .force_first_y, .force_first_z,
		.force_second_x, .force_second_y, .force_second_z,
		.apply_first, .apply_second, .violation_term, .last_result
	);

endmodule

>>> rtl/brp_checker.sv
// port level checks of the bump pair force block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module brp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] out_first,
	input logic [15:0] out_second,
	input logic [31:0] force_first_x,
	input logic [31:0] force_first_y,
	input logic [31:0] force_first_z,
	input logic        apply_first,
	input logic        apply_second,
	input logic [31:0] violation_term
);

	logic no_apply;
	logic first_zero;

	// derived conditions on the result transaction
	assign no_apply   = !apply_first && !apply_second;
	assign first_zero = force_first_x == 32'd0 && force_first_y == 32'd0
		&& force_first_z == 32'd0;

	// no bump means no violation term
	`BRP_ASSERT(a_no_bump_viol, out_valid && no_apply |-> violation_term == 32'd0, "viol no bump")

	// an atom not to be updated carries a zero force
	`BRP_ASSERT(a_first_zero, out_valid && !apply_first |-> first_zero, "force on skipped first")

	// only pairs with first index above second can bump
	`BRP_ASSERT(a_order, out_valid && out_first <= out_second |-> no_apply, "bump on unordered pair")

	// a stalled transaction stays in place
	`BRP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(violation_term) && $stable(out_first), "output changed under stall")

endmodule

bind bump_repulsion_pair_force_top brp_checker u_brp_checker (.*);

>>> test/bump_repulsion_pair_force_top_tb.sv
// testbench for the bump pair force block: directed pairs, config sweeps,
// backpressure and streaming, checked against a built-in force predictor
// depends on brp_pkg and bump_repulsion_pair_force_top
`timescale 1ns / 100ps

module bump_repulsion_pair_force_top_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 90;

	typedef longint unsigned u64_t;

	typedef struct {
		logic [15:0] first;
		logic [15:0] second;
		logic [31:0] dx, dy, dz;
		logic [19:0] contact;
		logic        bonded, r1, r2, last;
	} pair_t;

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] second;
		logic [31:0] f1x, f1y, f1z;
		logic [31:0] f2x, f2y, f2z;
		logic        ap1, ap2;
		logic [31:0] viol;
		logic        last;
	} force_res_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [15:0] atom_first, atom_second;
	logic [31:0] delta_x, delta_y, delta_z;
	logic [19:0] contact_distance;
	logic pair_bonded, first_restrained, second_restrained, end_of_list;
	force_res_t got;

	bump_repulsion_pair_force_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.atom_first(atom_first), .atom_second(atom_second),
		.delta_x(delta_x), .delta_y(delta_y), .delta_z(delta_z),
		.contact_distance(contact_distance), .pair_bonded(pair_bonded),
		.first_restrained(first_restrained), .second_restrained(second_restrained),
		.end_of_list(end_of_list),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_first(got.first), .out_second(got.second),
		.force_first_x(got.f1x), .force_first_y(got.f1y), .force_first_z(got.f1z),
		.force_second_x(got.f2x), .force_second_y(got.f2y), .force_second_z(got.f2z),
		.apply_first(got.ap1), .apply_second(got.ap2),
		.violation_term(got.viol), .last_result(got.last)
	);

	// predictor copy of the config registers
	logic [19:0] tol_reg;
	logic [23:0] weight_reg;

	force_res_t expected_forces[$];
	int errors;
	bit send_idle, recv_idle, hold_req;
	int quiet_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] clamp_force(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// expected force result of one pair under the current registers
	function automatic force_res_t predict_forces(pair_t p);
		force_res_t r;
		longint comp[3];
		longint unsigned mag[3];
		longint unsigned sum, w, viol, k;
		longint d, lb, q;
		bit bump;
		comp[0] = longint'($signed(p.dx));
		comp[1] = longint'($signed(p.dy));
		comp[2] = longint'($signed(p.dz));
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
			sum += mag[i] * mag[i];
		end
		d = int_sqrt(sum);
		lb = longint'(p.contact) - longint'(tol_reg);
		bump = (p.first > p.second) && !p.bonded && (d < lb) && !(p.r1 && p.r2);
		r = '0;
		r.first = p.first;
		r.second = p.second;
		r.last = p.last;
		if (bump) begin
			w = (u64_t'(weight_reg) * u64_t'(lb - d)) >> 16;
			viol = 6 * w;
			k = (p.r1 || p.r2) ? 2 : 1;
			r.viol = viol > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : viol[31:0];
			r.ap1 = !p.r1;
			r.ap2 = !p.r2;
			for (int i = 0; i < 3; i++) begin
				q = 0;
				if (d > 0) q = longint'((mag[i] * w * k) / u64_t'(d));
				if (comp[i] < 0) q = -q;
				if (!p.r1) begin
					case (i)
						0: r.f1x = clamp_force(-q);
						1: r.f1y = clamp_force(-q);
						default: r.f1z = clamp_force(-q);
					endcase
				end
				if (!p.r2) begin
					case (i)
						0: r.f2x = clamp_force(q);
						1: r.f2y = clamp_force(q);
						default: r.f2z = clamp_force(q);
					endcase
				end
			end
		end
		return r;
	endfunction

	// random pair, either likely to overlap or full-range noise
	function automatic pair_t random_pair(bit overlap_likely);
		pair_t p;
		p.first = 16'($urandom);
		p.second = 16'($urandom);
		p.dx = $urandom;
		p.dy = $urandom;
		p.dz = $urandom;
		p.contact = 20'($urandom);
		p.bonded = 1'($urandom_range(0, 1));
		p.r1 = 1'($urandom_range(0, 1));
		p.r2 = 1'($urandom_range(0, 1));
		p.last = ($urandom_range(0, 15) == 0);
		if (overlap_likely) begin
			p.second = 16'($urandom_range(0, 65534));
			if ($urandom_range(0, 7) != 0) p.first = 16'($urandom_range(p.second + 1, 65535));
			p.dx = int'($urandom_range(0, 1 << 19)) - (1 << 18);
			p.dy = int'($urandom_range(0, 1 << 19)) - (1 << 18);
			p.dz = int'($urandom_range(0, 1 << 19)) - (1 << 18);
			p.bonded = ($urandom_range(0, 7) == 0);
			p.r1 = ($urandom_range(0, 3) == 0);
			p.r2 = ($urandom_range(0, 3) == 0);
		end
		return p;
	endfunction

	// offer one pair and wait for the transaction
	task automatic send_pair(pair_t p);
		if (send_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		atom_first <= p.first;
		atom_second <= p.second;
		delta_x <= p.dx;
		delta_y <= p.dy;
		delta_z <= p.dz;
		contact_distance <= p.contact;
		pair_bonded <= p.bonded;
		first_restrained <= p.r1;
		second_restrained <= p.r2;
		end_of_list <= p.last;
		do @(posedge clk); while (in_stall);
		expected_forces.push_back(predict_forces(p));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		wait (expected_forces.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == brp_pkg::CFG_TOLERANCE) tol_reg = value[19:0];
		else if (idx == brp_pkg::CFG_FORCE_WEIGHT) weight_reg = value;
	endtask

	function automatic pair_t mk(logic [15:0] a1, logic [15:0] a2, int x, int y, int z,
			logic [19:0] c, logic b, logic r1, logic r2, logic last);
		pair_t p;
		p.first = a1; p.second = a2; p.dx = x; p.dy = y; p.dz = z;
		p.contact = c; p.bonded = b; p.r1 = r1; p.r2 = r2; p.last = last;
		return p;
	endfunction

	// extremes and every special case, first at reset settings, then with changed registers
	task automatic test_directed();
		send_pair(mk(5, 2, 32768, -16384, 0, 20'd131072, 0, 0, 0, 0));
		send_pair(mk(5, 2, -40000, 20000, 10000, 20'd131072, 0, 1, 0, 0));
		send_pair(mk(5, 2, 40000, -20000, -10000, 20'd131072, 0, 0, 1, 0));
		send_pair(mk(5, 2, 1000, 1000, 1000, 20'd131072, 0, 1, 1, 0));
		send_pair(mk(5, 2, 1000, 1000, 1000, 20'd131072, 1, 0, 0, 0));
		send_pair(mk(2, 5, 1000, 1000, 1000, 20'd131072, 0, 0, 0, 0));
		send_pair(mk(7, 7, 1000, 1000, 1000, 20'd131072, 0, 0, 0, 0));
		send_pair(mk(9, 1, 0, 0, 0, 20'd65536, 0, 0, 0, 0));
		send_pair(mk(9, 1, 0, 0, 0, 20'd65536, 0, 1, 0, 0));
		send_pair(mk(9, 1, 0, 0, 0, 20'd0, 0, 0, 0, 0));
		send_pair(mk(16'hFFFF, 0, 1, -1, 1, 20'hFFFFF, 0, 0, 0, 1));
		send_pair(mk(16'hFFFF, 16'hFFFE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			20'hFFFFF, 0, 0, 0, 0));
		send_pair(mk(16'hFFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			20'hFFFFF, 0, 0, 0, 1));
		send_pair(mk(3, 1, 0, 0, 20'hFFFFE, 20'hFFFFF, 0, 0, 0, 0));
		send_pair(mk(3, 1, 0, 0, 20'hFFFFF, 20'hFFFFF, 0, 0, 0, 0));
		wait_idle();
		// largest force weight and a non-positive bound
		write_reg(brp_pkg::CFG_FORCE_WEIGHT, 24'hFFFFFF);
		send_pair(mk(3, 1, 1, 0, 0, 20'hFFFFF, 0, 0, 0, 0));
		send_pair(mk(3, 1, -5, 3, 0, 20'hFFFFF, 0, 0, 1, 1));
		wait_idle();
		write_reg(brp_pkg::CFG_TOLERANCE, 24'h0_0100);
		send_pair(mk(3, 1, 0, 0, 0, 20'h00100, 0, 0, 0, 0));
		send_pair(mk(3, 1, 0, 0, 0, 20'h00101, 0, 0, 0, 0));
		send_pair(mk(3, 1, 0, 0, 0, 20'h00050, 0, 0, 0, 0));
		wait_idle();
	endtask

	// random pairs under several register settings, extremes included
	task automatic test_config_sweep();
		logic [23:0] tols[5], weights[5];
		tols = '{24'h0, 24'hFFFFF, 24'h0, 24'h1000, 24'h0};
		weights = '{24'h10000, 24'hFFFFFF, 24'h0, 24'h0, 24'h0};
		weights[3] = 24'($urandom);
		weights[4] = 24'($urandom_range(1, 24'h3FFFF));
		tols[4] = 24'($urandom_range(0, 24'h3FFF));
		for (int s = 0; s < 5; s++) begin
			write_reg(brp_pkg::CFG_TOLERANCE, tols[s]);
			write_reg(brp_pkg::CFG_FORCE_WEIGHT, weights[s]);
			// unused indexes must not disturb anything
			write_reg(2'd2, 24'($urandom));
			write_reg(2'd3, 24'($urandom));
			repeat (120) send_pair(random_pair($urandom_range(0, 4) != 0));
			wait_idle();
		end
	endtask

	// long receiver hold while the sender keeps offering
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (100) send_pair(random_pair(1));
		wait_idle();
	endtask

	// back-to-back streaming with no idling at all
	task automatic test_streaming();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		repeat (120) send_pair(random_pair($urandom_range(0, 5) != 0));
		in_valid <= 1'b0;
	endtask

	// receiver stall bursts and the long hold
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (recv_idle && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_forces.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
			end else begin
				force_res_t e;
				e = expected_forces.pop_front();
				if (e !== got) begin
					errors++;
					if (errors <= 10) $display("mismatch: expected %p actual %p", e, got);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		tol_reg = brp_pkg::TOLERANCE_RESET;
		weight_reg = brp_pkg::FORCE_WEIGHT_RESET;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		atom_first = '0;
		atom_second = '0;
		delta_x = '0;
		delta_y = '0;
		delta_z = '0;
		contact_distance = '0;
		pair_bonded = 1'b0;
		first_restrained = 1'b0;
		second_restrained = 1'b0;
		end_of_list = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_streaming();
		wait (expected_forces.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
